@@ rtl/prqs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready-queue scheduler package
// Shared types, codes and sizes of the ready-queue engine.
// ----------------------------------------------------------------------------
package prqs_pkg;

  localparam int unsigned MaxTasks      = 64;
  localparam int unsigned NumPriorities = 128;
  localparam int unsigned TaskW         = 6;
  localparam int unsigned PrioW         = 7;
  localparam int unsigned LinkW         = 7;
  localparam logic [LinkW-1:0] LinkNone = 7'd64;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_REINSERT = 2'd2,
    OP_SWITCH   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] priority_req;
    logic             requeue_running;
  } in_item_t;

  typedef struct packed {
    logic             preempt;
    logic             was_queued;
    logic [TaskW-1:0] next_task;
    logic             next_is_idle;
  } out_item_t;

  // Micro-operation sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_APP_RD,
    ST_APP_WR,
    ST_UNL_RD,
    ST_UNL_WR,
    ST_PICK,
    ST_HEAD_RD,
    ST_HEAD_LNK,
    ST_OUT
  } state_e;

  // Link memory port: one read, one write per cycle.
  typedef struct packed {
    logic             re;
    logic [TaskW-1:0] raddr;
    logic             we;
    logic [TaskW-1:0] waddr;
    logic             wnext_en;
    logic [LinkW-1:0] wnext;
    logic             wprev_en;
    logic [LinkW-1:0] wprev;
    logic             wprio_en;
    logic [PrioW-1:0] wprio;
  } link_req_t;

  typedef struct packed {
    logic [LinkW-1:0] next;
    logic [LinkW-1:0] prev;
    logic [PrioW-1:0] prio;
  } link_rsp_t;

  function automatic logic [PrioW-1:0] clamp_prio(input logic [PrioW-1:0] p);
    if (32'(p) >= NumPriorities) begin
      clamp_prio = PrioW'(NumPriorities - 1);
    end else begin
      clamp_prio = p;
    end
  endfunction

endpackage

@@ rtl/priority_ready_queue_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority ready-queue scheduler
// Per-priority FIFO ready lists in link and list memories, bitmap search.
// Longest path: a switch that requeues the running task, then reads the new
// head and unlinks it.
// Throughput: one item at a time; the next is taken when the result leaves.
// Reset: bitmap, queued flags and running task clear at once; no sweep.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  prqs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prqs_pkg::out_item_t out_data_o
);

  localparam int unsigned TW = prqs_pkg::TaskW;
  localparam int unsigned PW = prqs_pkg::PrioW;
  localparam int unsigned LW = prqs_pkg::LinkW;

  prqs_pkg::state_e state_q, state_d;

  logic [prqs_pkg::NumPriorities-1:0] bits_q, bits_d;
  logic [prqs_pkg::MaxTasks-1:0]      queued_q, queued_d;
  logic [TW-1:0] run_task_q, run_task_d;
  logic [PW-1:0] run_prio_q, run_prio_d;
  logic          run_valid_q, run_valid_d;

  prqs_pkg::in_item_t  item_q, item_d;
  prqs_pkg::out_item_t res_q, res_d;
  logic [TW-1:0] cur_task_q, cur_task_d;
  logic [PW-1:0] cur_prio_q, cur_prio_d;
  logic          app_after_q, app_after_d;
  logic          pick_after_q, pick_after_d;
  logic          out_valid_q, out_valid_d;

  prqs_pkg::link_req_t lreq;
  prqs_pkg::link_rsp_t lrsp;
  logic          lst_re, lst_wh, lst_wt;
  logic [PW-1:0] lst_raddr, lst_waddr;
  logic [TW-1:0] lst_whd, lst_wtd, lst_head, lst_tail;
  logic          enc_found;
  logic [PW-1:0] enc_best;

  // Second link write, issued in the following cycle: next link or prev link.
  logic          lw2_q, lw2_d;
  logic          lw2_nx_q, lw2_nx_d;
  logic [TW-1:0] lw2_addr_q, lw2_addr_d;
  logic [LW-1:0] lw2_val_q, lw2_val_d;

  prqs_link_mem u_link (
    .clk_i (clk_i),
    .req_i (lreq),
    .rsp_o (lrsp)
  );

  prqs_list_mem u_list (
    .clk_i        (clk_i),
    .re_i         (lst_re),
    .raddr_i      (lst_raddr),
    .whead_i      (lst_wh),
    .wtail_i      (lst_wt),
    .waddr_i      (lst_waddr),
    .whead_data_i (lst_whd),
    .wtail_data_i (lst_wtd),
    .head_o       (lst_head),
    .tail_o       (lst_tail)
  );

  prqs_prio_enc u_enc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bits_i  (bits_q),
    .found_o (enc_found),
    .best_o  (enc_best)
  );

  assign in_ready_o  = (state_q == prqs_pkg::ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prqs_pkg::ST_IDLE:    if (in_valid_i && in_ready_o) state_d = prqs_pkg::ST_DECODE;
      prqs_pkg::ST_DECODE: begin
        if (prqs_pkg::op_e'(item_q.opcode) == prqs_pkg::OP_SWITCH) begin
          if (run_valid_q && item_q.requeue_running && !queued_q[run_task_q]) begin
            state_d = prqs_pkg::ST_APP_RD;
          end else begin
            state_d = prqs_pkg::ST_PICK;
          end
        end else if (prqs_pkg::op_e'(item_q.opcode) == prqs_pkg::OP_ADD) begin
          state_d = queued_q[item_q.task_id] ? prqs_pkg::ST_OUT : prqs_pkg::ST_APP_RD;
        end else begin
          state_d = queued_q[item_q.task_id] ? prqs_pkg::ST_UNL_RD : prqs_pkg::ST_OUT;
        end
      end
      prqs_pkg::ST_APP_RD:  state_d = prqs_pkg::ST_APP_WR;
      prqs_pkg::ST_APP_WR:  state_d = pick_after_q ? prqs_pkg::ST_PICK : prqs_pkg::ST_OUT;
      prqs_pkg::ST_UNL_RD:  state_d = prqs_pkg::ST_UNL_WR;
      prqs_pkg::ST_UNL_WR: begin
        if (app_after_q) begin
          state_d = prqs_pkg::ST_APP_RD;
        end else begin
          state_d = prqs_pkg::ST_OUT;
        end
      end
      prqs_pkg::ST_PICK:     state_d = prqs_pkg::ST_HEAD_RD;
      prqs_pkg::ST_HEAD_RD:  state_d = enc_found ? prqs_pkg::ST_HEAD_LNK : prqs_pkg::ST_OUT;
      prqs_pkg::ST_HEAD_LNK: state_d = prqs_pkg::ST_UNL_RD;
      prqs_pkg::ST_OUT:      state_d = prqs_pkg::ST_IDLE;
      default:               state_d = prqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    logic [LW-1:0] pv, nx;
    logic [PW-1:0] up;
    bits_d       = bits_q;
    queued_d     = queued_q;
    run_task_d   = run_task_q;
    run_prio_d   = run_prio_q;
    run_valid_d  = run_valid_q;
    item_d       = item_q;
    res_d        = res_q;
    cur_task_d   = cur_task_q;
    cur_prio_d   = cur_prio_q;
    app_after_d  = app_after_q;
    pick_after_d = pick_after_q;
    out_valid_d  = out_valid_q;
    lw2_d        = 1'b0;
    lw2_nx_d     = lw2_nx_q;
    lw2_addr_d   = lw2_addr_q;
    lw2_val_d    = lw2_val_q;
    lreq         = '0;
    lst_re       = 1'b0;
    lst_raddr    = cur_prio_q;
    lst_wh       = 1'b0;
    lst_wt       = 1'b0;
    lst_waddr    = cur_prio_q;
    lst_whd      = cur_task_q;
    lst_wtd      = cur_task_q;
    pv           = lrsp.prev;
    nx           = lrsp.next;
    up           = lrsp.prio;

    if (lw2_q) begin
      lreq.we    = 1'b1;
      lreq.waddr = lw2_addr_q;
      if (lw2_nx_q) begin
        lreq.wnext_en = 1'b1;
        lreq.wnext    = lw2_val_q;
      end else begin
        lreq.wprev_en = 1'b1;
        lreq.wprev    = lw2_val_q;
      end
    end

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      prqs_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready_o) item_d = in_data_i;
      end
      prqs_pkg::ST_DECODE: begin
        res_d        = '0;
        app_after_d  = 1'b0;
        pick_after_d = 1'b0;
        if (prqs_pkg::op_e'(item_q.opcode) == prqs_pkg::OP_SWITCH) begin
          pick_after_d = 1'b1;
          cur_task_d   = run_task_q;
          cur_prio_d   = run_prio_q;
        end else begin
          res_d.was_queued = queued_q[item_q.task_id];
          cur_task_d       = item_q.task_id;
          cur_prio_d       = prqs_pkg::clamp_prio(item_q.priority_req);
          app_after_d      = prqs_pkg::op_e'(item_q.opcode) == prqs_pkg::OP_REINSERT;
          if (prqs_pkg::op_e'(item_q.opcode) == prqs_pkg::OP_ADD) begin
            res_d.preempt = !queued_q[item_q.task_id] && (!run_valid_q ||
                            prqs_pkg::clamp_prio(item_q.priority_req) < run_prio_q);
          end
          if (prqs_pkg::op_e'(item_q.opcode) != prqs_pkg::OP_ADD) begin
            lreq.re    = 1'b1;
            lreq.raddr = item_q.task_id;
          end
        end
      end
      prqs_pkg::ST_APP_RD: begin
        lst_re    = 1'b1;
        lst_raddr = cur_prio_q;
      end
      prqs_pkg::ST_APP_WR: begin
        lreq.we       = 1'b1;
        lreq.waddr    = cur_task_q;
        lreq.wnext_en = 1'b1;
        lreq.wnext    = prqs_pkg::LinkNone;
        lreq.wprev_en = 1'b1;
        lreq.wprio_en = 1'b1;
        lreq.wprio    = cur_prio_q;
        lst_wt        = 1'b1;
        if (bits_q[cur_prio_q]) begin
          lreq.wprev = LW'(lst_tail);
          // Link the old tail forward next cycle.
          lw2_d      = 1'b1;
          lw2_nx_d   = 1'b1;
          lw2_addr_d = lst_tail;
          lw2_val_d  = LW'(cur_task_q);
        end else begin
          lreq.wprev = prqs_pkg::LinkNone;
          lst_wh     = 1'b1;
        end
        bits_d[cur_prio_q]   = 1'b1;
        queued_d[cur_task_q] = 1'b1;
      end
      prqs_pkg::ST_UNL_RD: begin
        lst_re    = 1'b1;
        lst_raddr = up;
        cur_prio_d = up;
        lw2_val_d = pv;
      end
      prqs_pkg::ST_UNL_WR: begin
        pv = lw2_val_q;
        lreq.re = 1'b0;
        if (pv == prqs_pkg::LinkNone) begin
          lst_wh  = 1'b1;
          lst_whd = nx[TW-1:0];
        end
        if (nx == prqs_pkg::LinkNone) begin
          lst_wt  = 1'b1;
          lst_wtd = pv[TW-1:0];
        end
        if (pv == prqs_pkg::LinkNone && nx == prqs_pkg::LinkNone) begin
          bits_d[cur_prio_q] = 1'b0;
        end
        queued_d[cur_task_q] = 1'b0;
        if (pv != prqs_pkg::LinkNone) begin
          lreq.we       = 1'b1;
          lreq.waddr    = pv[TW-1:0];
          lreq.wnext_en = 1'b1;
          lreq.wnext    = nx;
        end
        if (nx != prqs_pkg::LinkNone) begin
          lw2_d      = 1'b1;
          lw2_nx_d   = 1'b0;
          lw2_addr_d = nx[TW-1:0];
          lw2_val_d  = pv;
        end
        if (app_after_q) cur_prio_d = prqs_pkg::clamp_prio(item_q.priority_req);
      end
      prqs_pkg::ST_PICK: begin
        pick_after_d = 1'b0;
      end
      prqs_pkg::ST_HEAD_RD: begin
        if (enc_found) begin
          lst_re     = 1'b1;
          lst_raddr  = enc_best;
          cur_prio_d = enc_best;
          res_d.next_is_idle = 1'b0;
          run_prio_d  = enc_best;
          run_valid_d = 1'b1;
        end else begin
          res_d.next_is_idle = 1'b1;
          res_d.next_task    = '0;
          run_valid_d        = 1'b0;
        end
      end
      prqs_pkg::ST_HEAD_LNK: begin
        cur_task_d      = lst_head;
        run_task_d      = lst_head;
        res_d.next_task = lst_head;
        lreq.re         = 1'b1;
        lreq.raddr      = lst_head;
      end
      prqs_pkg::ST_OUT: begin
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prqs_pkg::ST_IDLE;
      bits_q      <= '0;
      queued_q    <= '0;
      run_task_q  <= '0;
      run_prio_q  <= '0;
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      lw2_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      bits_q      <= bits_d;
      queued_q    <= queued_d;
      run_task_q  <= run_task_d;
      run_prio_q  <= run_prio_d;
      run_valid_q <= run_valid_d;
      out_valid_q <= out_valid_d;
      lw2_q       <= lw2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    res_q        <= res_d;
    cur_task_q   <= cur_task_d;
    cur_prio_q   <= cur_prio_d;
    app_after_q  <= app_after_d;
    pick_after_q <= pick_after_d;
    lw2_nx_q     <= lw2_nx_d;
    lw2_addr_q   <= lw2_addr_d;
    lw2_val_q    <= lw2_val_d;
  end

endmodule

@@ rtl/prqs_link_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready-queue link memory
// Per-task next, prev and queued priority, registered synchronous read.
// ----------------------------------------------------------------------------
module prqs_link_mem (
  input  logic                clk_i,
  input  prqs_pkg::link_req_t req_i,
  output prqs_pkg::link_rsp_t rsp_o
);

  logic [prqs_pkg::LinkW-1:0] next_mem [prqs_pkg::MaxTasks];
  logic [prqs_pkg::LinkW-1:0] prev_mem [prqs_pkg::MaxTasks];
  logic [prqs_pkg::PrioW-1:0] prio_mem [prqs_pkg::MaxTasks];

  always_ff @(posedge clk_i) begin
    if (req_i.we && req_i.wnext_en) begin
      next_mem[req_i.waddr] <= req_i.wnext;
    end
    if (req_i.we && req_i.wprev_en) begin
      prev_mem[req_i.waddr] <= req_i.wprev;
    end
    if (req_i.we && req_i.wprio_en) begin
      prio_mem[req_i.waddr] <= req_i.wprio;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rsp_o.next <= next_mem[req_i.raddr];
      rsp_o.prev <= prev_mem[req_i.raddr];
      rsp_o.prio <= prio_mem[req_i.raddr];
    end
  end

endmodule

@@ rtl/prqs_list_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready-queue list memory
// Per-priority head and tail, registered synchronous read.
// ----------------------------------------------------------------------------
module prqs_list_mem (
  input  logic                       clk_i,
  input  logic                       re_i,
  input  logic [prqs_pkg::PrioW-1:0] raddr_i,
  input  logic                       whead_i,
  input  logic                       wtail_i,
  input  logic [prqs_pkg::PrioW-1:0] waddr_i,
  input  logic [prqs_pkg::TaskW-1:0] whead_data_i,
  input  logic [prqs_pkg::TaskW-1:0] wtail_data_i,
  output logic [prqs_pkg::TaskW-1:0] head_o,
  output logic [prqs_pkg::TaskW-1:0] tail_o
);

  logic [prqs_pkg::TaskW-1:0] head_mem [prqs_pkg::NumPriorities];
  logic [prqs_pkg::TaskW-1:0] tail_mem [prqs_pkg::NumPriorities];

  always_ff @(posedge clk_i) begin
    if (whead_i) begin
      head_mem[waddr_i] <= whead_data_i;
    end
    if (wtail_i) begin
      tail_mem[waddr_i] <= wtail_data_i;
    end
    if (re_i) begin
      head_o <= head_mem[raddr_i];
      tail_o <= tail_mem[raddr_i];
    end
  end

endmodule

@@ rtl/prqs_prio_enc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready bitmap encoder
// Registered search for the most urgent non-empty priority.
// ----------------------------------------------------------------------------
module prqs_prio_enc (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [prqs_pkg::NumPriorities-1:0] bits_i,
  output logic                               found_o,
  output logic [prqs_pkg::PrioW-1:0]         best_o
);

  localparam int unsigned Groups = 8;
  localparam int unsigned GroupW = prqs_pkg::NumPriorities / Groups;

  logic [Groups-1:0]          grp_any_d, grp_any_q;
  logic [3:0]                 grp_idx_d [Groups];
  logic [3:0]                 grp_idx_q [Groups];
  logic                       found_d;
  logic [prqs_pkg::PrioW-1:0] best_d;

  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_any_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int b = GroupW - 1; b >= 0; b--) begin
        if (bits_i[g*GroupW + b]) begin
          grp_any_d[g] = 1'b1;
          grp_idx_d[g] = 4'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
    end else begin
      grp_any_q <= grp_any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < Groups; g++) begin
      grp_idx_q[g] <= grp_idx_d[g];
    end
  end

  always_comb begin
    found_d = 1'b0;
    best_d  = '0;
    for (int g = Groups - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found_d = 1'b1;
        best_d  = prqs_pkg::PrioW'(g * GroupW) + prqs_pkg::PrioW'(grp_idx_q[g]);
      end
    end
  end

  assign found_o = found_d;
  assign best_o  = best_d;

endmodule

@@ test/tb_priority_ready_queue_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready-queue scheduler testbench
// Drives add, remove, reinsert and switch items with random gaps and stalls,
// predicts each result from a behavioural copy of the ready lists and
// compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler;

  localparam int NoLink = 64;

  class sched_scoreboard;
    bit [127:0]  ready_map;
    int          head_of[128];
    int          tail_of[128];
    int          next_of[64];
    int          prev_of[64];
    int          prio_of[64];
    bit          queued[64];
    int          run_task;
    int          run_prio;
    bit          run_valid;
    prqs_pkg::out_item_t pending[$];
    int          errors;
    int          checked;
    int          switches;
    int          idles;
    int          preempts;

    function new();
      ready_map = '0;
      foreach (queued[i]) queued[i] = 0;
      run_task = 0;
      run_prio = 0;
      run_valid = 0;
      errors = 0;
      checked = 0;
      switches = 0;
      idles = 0;
      preempts = 0;
    endfunction

    function void link_tail(int t, int p);
      next_of[t] = NoLink;
      if (ready_map[p]) begin
        prev_of[t] = tail_of[p];
        next_of[tail_of[p]] = t;
      end else begin
        prev_of[t] = NoLink;
        head_of[p] = t;
      end
      tail_of[p] = t;
      ready_map[p] = 1;
      queued[t] = 1;
      prio_of[t] = p;
    endfunction

    function void cut_out(int t);
      int p;
      int pv;
      int nx;
      p = prio_of[t];
      pv = prev_of[t];
      nx = next_of[t];
      if (pv == NoLink) head_of[p] = nx;
      else next_of[pv] = nx;
      if (nx == NoLink) tail_of[p] = pv;
      else prev_of[nx] = pv;
      if (pv == NoLink && nx == NoLink) ready_map[p] = 0;
      queued[t] = 0;
    endfunction

    function void note_item(prqs_pkg::in_item_t it);
      prqs_pkg::out_item_t r;
      int t;
      int p;
      int best;
      r = '0;
      t = it.task_id;
      p = it.priority_req;
      if (prqs_pkg::op_e'(it.opcode) == prqs_pkg::OP_SWITCH) begin
        switches++;
        if (run_valid && it.requeue_running && !queued[run_task])
          link_tail(run_task, run_prio);
        best = -1;
        for (int q = 127; q >= 0; q--) if (ready_map[q]) best = q;
        if (best < 0) begin
          run_valid = 0;
          r.next_is_idle = 1;
          idles++;
        end else begin
          run_task = head_of[best];
          cut_out(run_task);
          run_prio = best;
          run_valid = 1;
          r.next_task = run_task[5:0];
        end
      end else begin
        r.was_queued = queued[t];
        case (prqs_pkg::op_e'(it.opcode))
          prqs_pkg::OP_ADD: if (!queued[t]) begin
            link_tail(t, p);
            r.preempt = !run_valid || p < run_prio;
            if (r.preempt) preempts++;
          end
          prqs_pkg::OP_REMOVE: if (queued[t]) cut_out(t);
          default: if (queued[t]) begin
            cut_out(t);
            link_tail(t, p);
          end
        endcase
      end
      pending.push_back(r);
    endfunction

    function void check_result(prqs_pkg::out_item_t got);
      prqs_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.preempt !== exp.preempt)
        $display("%0t: preempt exp %0b got %0b", $time, exp.preempt, got.preempt);
      if (got.was_queued !== exp.was_queued)
        $display("%0t: was_queued exp %0b got %0b", $time, exp.was_queued,
                 got.was_queued);
      if (got.next_task !== exp.next_task)
        $display("%0t: next_task exp %0d got %0d", $time, exp.next_task,
                 got.next_task);
      if (got.next_is_idle !== exp.next_is_idle)
        $display("%0t: next_is_idle exp %0b got %0b", $time, exp.next_is_idle,
                 got.next_is_idle);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  prqs_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  prqs_pkg::out_item_t out_data_o;

  sched_scoreboard sb;
  bit        hold_off_req;
  bit        hold_off_done;

  priority_ready_queue_scheduler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Valid stays high after an accept; drop it only for a gap or a pause.
  task automatic send_item(input prqs_pkg::op_e op, input int t, input int p,
                           input bit rq, input int gap);
    prqs_pkg::in_item_t it;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    it.opcode = op;
    it.task_id = t[5:0];
    it.priority_req = p[6:0];
    it.requeue_running = rq;
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  task automatic stop_sending();
    in_valid_i <= 0;
  endtask

  task automatic send_random(input bit noisy);
    int r;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    r = $urandom_range(0, 99);
    if (noisy)
      send_item(prqs_pkg::op_e'($urandom_range(0, 3)), $urandom_range(0, 63),
                $urandom_range(0, 127), $urandom_range(0, 1), gap);
    else if (r < 45)
      send_item(prqs_pkg::OP_ADD, $urandom_range(0, 15),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, 7),
                0, gap);
    else if (r < 55)
      send_item(prqs_pkg::OP_REMOVE, $urandom_range(0, 15), $urandom_range(0, 127),
                0, gap);
    else if (r < 67)
      send_item(prqs_pkg::OP_REINSERT, $urandom_range(0, 15), $urandom_range(0, 7),
                0, gap);
    else
      send_item(prqs_pkg::OP_SWITCH, $urandom_range(0, 63), $urandom_range(0, 127),
                $urandom_range(0, 3) != 0, gap);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall per item, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready_i = 0;
    hold_off_done = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 0;
        repeat (60) @(posedge clk_i);
        hold_off_done = 1;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready_i <= 0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
    end
  end

  initial begin
    sb = new();
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    hold_off_req = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: idle switch, field extremes, every special case
    send_item(prqs_pkg::OP_SWITCH, 0, 0, 1, 0);
    send_item(prqs_pkg::OP_REMOVE, 5, 0, 0, 0);
    send_item(prqs_pkg::OP_REINSERT, 5, 3, 0, 0);
    send_item(prqs_pkg::OP_ADD, 63, 127, 0, 0);
    send_item(prqs_pkg::OP_ADD, 0, 0, 1, 0);
    send_item(prqs_pkg::OP_ADD, 0, 9, 0, 1);
    send_item(prqs_pkg::OP_ADD, 42, 127, 1, 0);
    send_item(prqs_pkg::OP_ADD, 21, 85, 0, 0);
    send_item(prqs_pkg::OP_SWITCH, 63, 127, 0, 0);
    send_item(prqs_pkg::OP_ADD, 7, 0, 0, 0);
    send_item(prqs_pkg::OP_ADD, 8, 1, 0, 2);
    send_item(prqs_pkg::OP_REINSERT, 42, 0, 0, 0);
    send_item(prqs_pkg::OP_REMOVE, 7, 0, 0, 0);
    send_item(prqs_pkg::OP_SWITCH, 0, 0, 1, 0);
    send_item(prqs_pkg::OP_ADD, 0, 0, 0, 0);
    send_item(prqs_pkg::OP_SWITCH, 0, 0, 1, 0);
    send_item(prqs_pkg::OP_SWITCH, 0, 0, 0, 0);
    send_item(prqs_pkg::OP_SWITCH, 0, 0, 1, 0);
    send_item(prqs_pkg::OP_SWITCH, 0, 0, 1, 0);
    send_item(prqs_pkg::OP_SWITCH, 0, 0, 0, 0);
    send_item(prqs_pkg::OP_SWITCH, 0, 0, 0, 0);
    send_item(prqs_pkg::OP_SWITCH, 0, 0, 1, 0);

    // random content, the first batch under a long receiver hold-off
    hold_off_req = 1;
    for (int i = 0; i < 730; i++) begin
      send_random($urandom_range(0, 9) == 0);
      if (i == 300) begin
        stop_sending();
        wait_drained();
        repeat (20) @(posedge clk_i);
      end
    end
    stop_sending();
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("tb: %0d results checked, %0d switches (%0d idle), %0d preemptions",
             sb.checked, sb.switches, sb.idles, sb.preempts);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/prqs_pkg.sv
rtl/prqs_link_mem.sv
rtl/prqs_list_mem.sv
rtl/prqs_prio_enc.sv
rtl/priority_ready_queue_scheduler.sv
test/tb_priority_ready_queue_scheduler.sv
